/* rtl/vtd_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex tuple dedup package
// Shared types and constants for the vertex tuple deduplicator.
// ----------------------------------------------------------------------------
package vtd_pkg;

   localparam int MaxUnique  = 1024;
   localparam int SlotBits   = $clog2(MaxUnique);
   localparam int CountBits  = $clog2(MaxUnique + 1);
   localparam int KeyBits    = 64;
   localparam int UidBits    = 10;

   typedef struct packed {
      logic [15:0] position_index;
      logic [15:0] colour_index;
      logic [15:0] texcoord_index;
      logic [15:0] normal_index;
   } req_type;

   typedef struct packed {
      logic [UidBits-1:0] unique_index;
      logic               is_new;
      logic               overflow;
   } rsp_type;

endpackage

/* rtl/vtd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module vtd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/vtd_front.sv */
// ----------------------------------------------------------------------------
// Dedup front end
// Accepts requests into a two-entry queue that feeds the search engine.
// ----------------------------------------------------------------------------
module vtd_front import vtd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    q_valid,
   output req_type q_data,
   input  logic    q_take
);

   req_type    slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, take_ok;

   assign req_full = (cnt_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign take_ok  = q_take && q_valid;
   assign q_data   = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ take_ok;
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      cnt_in    = cnt_ff + {1'b0, push_ok} - {1'b0, take_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

/* rtl/vtd_back.sv */
// ----------------------------------------------------------------------------
// Dedup back end
// Scans stored keys one per cycle, inserts new tuples, holds the response.
// ----------------------------------------------------------------------------
module vtd_back import vtd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  req_type q_data,
   output logic    q_take,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [KeyBits-1:0]    key_ff;
   logic [CountBits-1:0]  count_ff;
   logic [CountBits-1:0]  addr_ff;   // address issued to the RAM
   logic                  rd_vld_ff;
   logic [SlotBits-1:0]   rd_slot_ff;
   rsp_type               res_ff;    // result of the finished search
   rsp_type               rsp_ff;
   logic                  full_ff;
   logic                  wr_en;
   logic [KeyBits-1:0]    rd_key;
   logic                  hit, last_issued;

   assign rsp_empty = !full_ff;
   assign rsp_data  = rsp_ff;
   assign q_take    = (state_ff == ST_IDLE) && q_valid;
   assign hit       = rd_vld_ff && (rd_key == key_ff);
   assign last_issued = (addr_ff >= count_ff);
   assign wr_en     = (state_ff == ST_SCAN) && !hit && !rd_vld_ff && last_issued
                      && (count_ff < CountBits'(MaxUnique));

   vtd_ram #(.Width(KeyBits), .Depth(MaxUnique)) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[SlotBits-1:0]),
      .wr_data (key_ff),
      .rd_addr (addr_ff[SlotBits-1:0]),
      .rd_data (rd_key)
   );

   // Sequence search, insert and response hold
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         full_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
         addr_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  key_ff    <= q_data;
                  addr_ff   <= '0;
                  rd_vld_ff <= 1'b0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_vld_ff  <= !last_issued && !hit;
               rd_slot_ff <= addr_ff[SlotBits-1:0];
               if (!last_issued) begin
                  addr_ff <= addr_ff + 1'b1;
               end
               if (hit) begin
                  res_ff    <= '{unique_index: UidBits'(rd_slot_ff),
                                 is_new: 1'b0, overflow: 1'b0};
                  state_ff  <= ST_DONE;
               end else if (!rd_vld_ff && last_issued) begin
                  if (wr_en) begin
                     res_ff   <= '{unique_index: UidBits'(count_ff),
                                   is_new: 1'b1, overflow: 1'b0};
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     res_ff <= '{unique_index: '0, is_new: 1'b0, overflow: 1'b1};
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // Hand the result over once the response register is free
               if (!full_ff) begin
                  rsp_ff   <= res_ff;
                  full_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (full_ff && rsp_pop) begin
            full_ff <= 1'b0;
         end
      end
   end

endmodule

/* rtl/vertex_tuple_deduplicator.sv */
// Each request is compared with the stored tuples in order until a hit or the end;
//   the key RAM is read one entry per cycle, so throughput follows the table fill.
// A response waits in its own register while the next request is searched.
// Reset clears the tuple count and queues; key RAM contents need no clearing.
// ----------------------------------------------------------------------------
// Vertex tuple deduplicator
// Assigns dense indices to distinct vertex index tuples.
// ----------------------------------------------------------------------------
module vertex_tuple_deduplicator import vtd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    q_valid, q_take;
   req_type q_data;

   vtd_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .q_valid, .q_data, .q_take
   );

   vtd_back u_back (
      .clock, .reset, .q_valid, .q_data, .q_take,
      .rsp_empty, .rsp_pop, .rsp_data
   );

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex tuple deduplicator testbench
// Drives corner tuples through the request queue and checks every response
// against a predictor that keeps its own tuple table. Directed extremes and
// repeats come first. Random traffic then mixes repeats, near misses and fresh
// tuples until the table fills and overflow shows up. Both sides stall at
// random.
// ----------------------------------------------------------------------------
module tb;
   import vtd_pkg::*;

   localparam int NumRandom  = 1830;
   localparam int CalmItems  = 150;
   localparam int IdleLimit  = 20000;
   localparam int DrainWait  = MaxUnique + 100;
   localparam int LongHold   = 400;

   // Predicts dense indices and holds the expected responses in order
   class dedup_scoreboard;
      req_type table_keys[$];
      rsp_type expected_rsp[$];
      int      errors;
      int      num_new;
      int      num_hit;
      int      num_ovf;

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      // Work out the response for an accepted request and queue it
      function void note_request(req_type r);
         rsp_type p;
         int      slot;
         slot = -1;
         foreach (table_keys[i]) if (table_keys[i] == r && slot < 0) slot = i;
         p = '0;
         if (slot >= 0) begin
            p.unique_index = UidBits'(slot);
            num_hit++;
         end else if (table_keys.size() >= MaxUnique) begin
            p.overflow = 1'b1;
            num_ovf++;
         end else begin
            p.unique_index = UidBits'(table_keys.size());
            p.is_new = 1'b1;
            table_keys = {table_keys, r};
            num_new++;
         end
         expected_rsp = {expected_rsp, p};
      endfunction

      // Compare a response with the oldest expectation
      task check_response(rsp_type d);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            report($sformatf("response with nothing expected: %p", d));
         end else begin
            e = expected_rsp.pop_front();
            if (d.unique_index !== e.unique_index)
               report($sformatf("unique_index %0d, expected %0d",
                                d.unique_index, e.unique_index));
            if (d.is_new !== e.is_new)
               report($sformatf("is_new %b, expected %b", d.is_new, e.is_new));
            if (d.overflow !== e.overflow)
               report($sformatf("overflow %b, expected %b", d.overflow, e.overflow));
         end
      endtask

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   dedup_scoreboard sb;
   req_type         sent[$];
   bit              calm;
   bit              hold_request;
   int              idle_cycles;

   vertex_tuple_deduplicator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Check responses, note requests, and watch for a stuck block
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) sb.check_response(rsp_data);
         if (req_push && !req_full) sb.note_request(req_data);
         if ((rsp_pop && !rsp_empty) || (req_push && !req_full)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
               $display("timeout after %0d cycles with no progress", IdleLimit);
               $display("** vertex_tuple_deduplicator: FAILED **");
               $finish;
            end
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LongHold - 1;
            rsp_pop <= 1'b0;
         end else if (!calm && !reset && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until accepted
   task send_tuple(req_type t);
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= t;
      sent = {sent, t};
      do @(posedge clock); while (req_full);
   endtask

   task idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
   endtask

   function req_type make_tuple(logic [15:0] p, logic [15:0] c, logic [15:0] t,
                                logic [15:0] n);
      req_type r;
      r.position_index = p;
      r.colour_index   = c;
      r.texcoord_index = t;
      r.normal_index   = n;
      return r;
   endfunction

   // Pick a random request: repeats, near misses, fresh tuples
   function req_type random_tuple();
      req_type r;
      int      sel;
      sel = $urandom_range(0, 99);
      if (sent.size() > 0 && sel < 30) begin
         r = sent[$urandom_range(0, sent.size() - 1)];
      end else if (sent.size() > 0 && sel < 40) begin
         r = sent[$urandom_range(0, sent.size() - 1)];
         r[$urandom_range(0, KeyBits - 1)] ^= 1'b1;
      end else begin
         r = {$urandom, $urandom};
      end
      return r;
   endfunction

   initial begin
      sb = new();
      calm = 1'b0;
      hold_request = 1'b0;
      idle_cycles = 0;
      req_push = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, each field alone at max, repeats, single-bit misses
      send_tuple(make_tuple(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_tuple(make_tuple(16'hffff, 16'hffff, 16'hffff, 16'hffff));
      send_tuple(make_tuple(16'hffff, 16'h0000, 16'h0000, 16'h0000));
      send_tuple(make_tuple(16'h0000, 16'hffff, 16'h0000, 16'h0000));
      send_tuple(make_tuple(16'h0000, 16'h0000, 16'hffff, 16'h0000));
      send_tuple(make_tuple(16'h0000, 16'h0000, 16'h0000, 16'hffff));
      send_tuple(make_tuple(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_tuple(make_tuple(16'hffff, 16'hffff, 16'hffff, 16'hffff));
      send_tuple(make_tuple(16'h8000, 16'h0000, 16'h0000, 16'h0000));
      send_tuple(make_tuple(16'h0000, 16'h0001, 16'h0000, 16'h0000));
      send_tuple(make_tuple(16'h0000, 16'h0000, 16'h8000, 16'h0000));
      send_tuple(make_tuple(16'h0000, 16'h0000, 16'h0000, 16'h0001));
      send_tuple(make_tuple(16'hfffe, 16'hffff, 16'hffff, 16'hffff));
      send_tuple(make_tuple(16'h0000, 16'hffff, 16'h0000, 16'h0000));
      send_tuple(make_tuple(16'h1234, 16'h5678, 16'h9abc, 16'hdef0));
      send_tuple(make_tuple(16'h1234, 16'h5678, 16'h9abc, 16'hdef0));

      // Long receiver hold-off while requests keep coming
      hold_request = 1'b1;
      for (int k = 0; k < NumRandom; k++) begin
         if (k == 700) begin
            // Pause until every response is back
            @(negedge clock);
            req_push <= 1'b0;
            while (sb.pending() > 0) @(posedge clock);
         end
         if (k >= NumRandom - CalmItems) calm = 1'b1;
         if (!calm && $urandom_range(0, 9) == 0) idle_sender($urandom_range(1, 17));
         send_tuple(random_tuple());
      end

      // Drain, then leave room for any stray response
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      $display("covered %0d requests: %0d new tuples, %0d repeats, %0d overflows",
               sb.num_new + sb.num_hit + sb.num_ovf, sb.num_new, sb.num_hit, sb.num_ovf);
      $display("table reached %0d of %0d entries", sb.table_keys.size(), MaxUnique);
      if (sb.errors == 0) begin
         $display("** vertex_tuple_deduplicator: PASSED **");
      end else begin
         $display("** vertex_tuple_deduplicator: FAILED **");
      end
      $finish;
   end

endmodule
